// ===== hdl/fat_chain_table_engine_assert.svh =====
// Assertion macros for the chain table engine, clocked on clk, disabled in reset.
`ifndef FAT_CHAIN_TABLE_ENGINE_ASSERT_SVH
`define FAT_CHAIN_TABLE_ENGINE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define FCT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define FCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/fct_pkg.sv =====
// Shared types and constants of the chain table engine.
`timescale 1ns / 1ps
`default_nettype none

package fct_pkg;

  // Table geometry: every entry is one byte and indexes the whole table.
  localparam int TABLE_AW    = 8;
  localparam int TABLE_DEPTH = 1 << TABLE_AW;
  localparam int CMD_W       = 3;

  // Sectors on the disk; the last one holds the tables.
  localparam int SECTOR_COUNT = 256;
  // First sector number that an append may not hand out.
  localparam int FULL_LIMIT   = (SECTOR_COUNT - 1 < 255) ? SECTOR_COUNT - 1 : 255;

  // Marker for "no entry" and "end of chain".
  localparam logic [TABLE_AW-1:0] NONE_MARK  = '1;
  // Links followed before a chain walk gives up.
  localparam logic [TABLE_AW-1:0] WALK_LIMIT = '1;
  // Last file number that a new-file search looks at.
  localparam logic [TABLE_AW-1:0] NEW_LAST   = NONE_MARK - 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_DIR   = 3'd0,
    CMD_WR_CHAIN = 3'd1,
    CMD_RD_DIR   = 3'd2,
    CMD_RD_CHAIN = 3'd3,
    CMD_NEW      = 3'd4,
    CMD_SIZE     = 3'd5,
    CMD_APPEND   = 3'd6,
    CMD_LOCATE   = 3'd7
  } fct_cmd_t;

  // One table port request: a read address and an optional write.
  typedef struct packed {
    logic [TABLE_AW-1:0] rd_addr;
    logic                wr_en;
    logic [TABLE_AW-1:0] wr_addr;
    logic [TABLE_AW-1:0] wr_data;
  } fct_mem_req_t;

endpackage

`default_nettype wire

// ===== hdl/fct_in_if.sv =====
// Command channel: valid/ready plus one command word.
`timescale 1ns / 1ps
`default_nettype none

interface fct_in_if import fct_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [TABLE_AW-1:0] file_num;
  logic [TABLE_AW-1:0] location;
  logic [TABLE_AW-1:0] entry_index;
  logic [TABLE_AW-1:0] entry_value;

  modport source (
    output valid, command, file_num, location, entry_index, entry_value,
    input  ready
  );
  modport sink (
    input  valid, command, file_num, location, entry_index, entry_value,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/fct_out_if.sv =====
// Result channel: valid/ready plus one result word.
`timescale 1ns / 1ps
`default_nettype none

interface fct_out_if import fct_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TABLE_AW-1:0] result_value;
  logic                failed;

  modport source (
    output valid, result_value, failed,
    input  ready
  );
  modport sink (
    input  valid, result_value, failed,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/fct_table.sv =====
// One 256 x 8 table: synchronous read, one write port, entries read as NONE until written.
`timescale 1ns / 1ps
`default_nettype none

module fct_table import fct_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire fct_mem_req_t        req,
  output logic [TABLE_AW-1:0]      rd_data
);

  logic [TABLE_AW-1:0]    mem_r [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] written_r;
  logic [TABLE_AW-1:0]    rd_word_r;
  logic                   rd_written_r;

  // Mark entries as written; reset returns the table to its formatted state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (req.wr_en) begin
      written_r[req.wr_addr] <= 1'b1;
    end
  end

  // Store and fetch the data, read in the cycle after the address.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    rd_word_r    <= mem_r[req.rd_addr];
    rd_written_r <= written_r[req.rd_addr];
  end

  assign rd_data = rd_written_r ? rd_word_r : NONE_MARK;

endmodule

`default_nettype wire

// ===== hdl/fct_ctrl.sv =====
// Command sequencer: walks the tables, updates them and registers the result word.
`timescale 1ns / 1ps
`default_nettype none

module fct_ctrl import fct_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  fct_in_if.sink               in_ch,
  fct_out_if.source            out_ch,
  output fct_mem_req_t         dir_req,
  output fct_mem_req_t         chain_req,
  input  wire logic [TABLE_AW-1:0] dir_rd_data,
  input  wire logic [TABLE_AW-1:0] chain_rd_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_NEW,
    S_HEAD,
    S_WALK,
    S_APP_HEAD,
    S_APP_EVAL,
    S_APP_TGT,
    S_APP_CLR,
    S_DONE
  } state_t;

  // What to do with the sector reached at the end of a chain walk.
  typedef enum logic [1:0] {
    W_SIZE,
    W_LOCATE,
    W_SCAN,
    W_TAIL
  } walk_mode_t;

  state_t              state_r, state_nxt;
  fct_cmd_t            cmd_r, cmd_nxt;
  logic [TABLE_AW-1:0] num_r, num_nxt;
  logic [TABLE_AW-1:0] loc_r, loc_nxt;
  logic [TABLE_AW-1:0] idx_r, idx_nxt;
  logic [TABLE_AW-1:0] val_r, val_nxt;
  logic [TABLE_AW-1:0] cur_r, cur_nxt;
  logic [TABLE_AW-1:0] links_r, links_nxt;
  logic [TABLE_AW-1:0] limit_r, limit_nxt;
  walk_mode_t          mode_r, mode_nxt;
  logic [TABLE_AW-1:0] i_r, i_nxt;
  logic                any_r, any_nxt;
  logic [TABLE_AW-1:0] high_r, high_nxt;
  logic [TABLE_AW-1:0] next_r, next_nxt;
  logic [TABLE_AW-1:0] res_value_r, res_value_nxt;
  logic                res_fail_r, res_fail_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [TABLE_AW-1:0] out_value_r, out_value_nxt;
  logic                out_failed_r, out_failed_nxt;

  logic                accept;
  logic                walk_stop;
  logic [TABLE_AW:0]   cand;

  assign in_ch.ready         = (state_r == S_IDLE);
  assign accept              = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.failed       = out_failed_r;

  assign walk_stop = (links_r == limit_r) || (chain_rd_data == NONE_MARK);
  assign cand      = any_r ? ({1'b0, high_r} + (TABLE_AW+1)'(1)) : '0;

  // Sequence one command at a time.
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    num_nxt        = num_r;
    loc_nxt        = loc_r;
    idx_nxt        = idx_r;
    val_nxt        = val_r;
    cur_nxt        = cur_r;
    links_nxt      = links_r;
    limit_nxt      = limit_r;
    mode_nxt       = mode_r;
    i_nxt          = i_r;
    any_nxt        = any_r;
    high_nxt       = high_r;
    next_nxt       = next_r;
    res_value_nxt  = res_value_r;
    res_fail_nxt   = res_fail_r;
    out_value_nxt  = out_value_r;
    out_failed_nxt = out_failed_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    dir_req        = '0;
    chain_req      = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt   = fct_cmd_t'(in_ch.command);
          num_nxt   = in_ch.file_num;
          loc_nxt   = in_ch.location;
          idx_nxt   = in_ch.entry_index;
          val_nxt   = in_ch.entry_value;
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        res_value_nxt = '0;
        res_fail_nxt  = 1'b0;
        case (cmd_r)
          CMD_WR_DIR: begin
            dir_req.wr_en   = 1'b1;
            dir_req.wr_addr = idx_r;
            dir_req.wr_data = val_r;
            state_nxt       = S_DONE;
          end
          CMD_WR_CHAIN: begin
            chain_req.wr_en   = 1'b1;
            chain_req.wr_addr = idx_r;
            chain_req.wr_data = val_r;
            state_nxt         = S_DONE;
          end
          CMD_RD_DIR: begin
            dir_req.rd_addr = idx_r;
            state_nxt       = S_READ;
          end
          CMD_RD_CHAIN: begin
            chain_req.rd_addr = idx_r;
            state_nxt         = S_READ;
          end
          CMD_NEW: begin
            dir_req.rd_addr = '0;
            i_nxt           = '0;
            state_nxt       = S_NEW;
          end
          CMD_SIZE, CMD_LOCATE: begin
            dir_req.rd_addr = num_r;
            state_nxt       = S_HEAD;
          end
          CMD_APPEND: begin
            dir_req.rd_addr = '0;
            i_nxt           = '0;
            any_nxt         = 1'b0;
            high_nxt        = '0;
            state_nxt       = S_APP_HEAD;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      // Take the entry fetched for a direct read.
      S_READ: begin
        res_value_nxt = (cmd_r == CMD_RD_DIR) ? dir_rd_data : chain_rd_data;
        res_fail_nxt  = 1'b0;
        state_nxt     = S_DONE;
      end

      // Scan the directory for the first free file number.
      S_NEW: begin
        if (dir_rd_data == NONE_MARK) begin
          res_value_nxt = i_r;
          res_fail_nxt  = 1'b0;
          state_nxt     = S_DONE;
        end else if (i_r == NEW_LAST) begin
          res_value_nxt = NONE_MARK;
          res_fail_nxt  = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          i_nxt           = TABLE_AW'(i_r + 1'b1);
          dir_req.rd_addr = TABLE_AW'(i_r + 1'b1);
        end
      end

      // Start a size or locate walk from the file's first sector.
      S_HEAD: begin
        if (dir_rd_data == NONE_MARK) begin
          res_value_nxt = (cmd_r == CMD_SIZE) ? '0 : NONE_MARK;
          res_fail_nxt  = (cmd_r != CMD_SIZE);
          state_nxt     = S_DONE;
        end else if (cmd_r == CMD_LOCATE && loc_r == NONE_MARK) begin
          res_value_nxt = NONE_MARK;
          res_fail_nxt  = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          cur_nxt           = dir_rd_data;
          links_nxt         = '0;
          limit_nxt         = (cmd_r == CMD_SIZE) ? WALK_LIMIT : loc_r;
          mode_nxt          = (cmd_r == CMD_SIZE) ? W_SIZE : W_LOCATE;
          chain_req.rd_addr = dir_rd_data;
          state_nxt         = S_WALK;
        end
      end

      // Follow one link per cycle; the fetched entry addresses the next read.
      S_WALK: begin
        if (!walk_stop) begin
          cur_nxt           = chain_rd_data;
          links_nxt         = TABLE_AW'(links_r + 1'b1);
          chain_req.rd_addr = chain_rd_data;
        end else begin
          case (mode_r)
            W_SIZE: begin
              res_value_nxt = (links_r == WALK_LIMIT) ? WALK_LIMIT
                                                      : TABLE_AW'(links_r + 1'b1);
              res_fail_nxt  = 1'b0;
              state_nxt     = S_DONE;
            end
            W_LOCATE: begin
              res_value_nxt = (links_r == limit_r) ? cur_r : NONE_MARK;
              res_fail_nxt  = (links_r != limit_r);
              state_nxt     = S_DONE;
            end
            W_SCAN: begin
              if (!any_r || cur_r > high_r) begin
                high_nxt = cur_r;
              end
              any_nxt = 1'b1;
              if (i_r == NONE_MARK) begin
                state_nxt = S_APP_EVAL;
              end else begin
                i_nxt           = TABLE_AW'(i_r + 1'b1);
                dir_req.rd_addr = TABLE_AW'(i_r + 1'b1);
                state_nxt       = S_APP_HEAD;
              end
            end
            W_TAIL: begin
              chain_req.wr_en   = 1'b1;
              chain_req.wr_addr = cur_r;
              chain_req.wr_data = next_r;
              state_nxt         = S_APP_CLR;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // Walk the leading run of used files in turn to find the highest last sector.
      S_APP_HEAD: begin
        if (dir_rd_data == NONE_MARK) begin
          state_nxt = S_APP_EVAL;
        end else begin
          cur_nxt           = dir_rd_data;
          links_nxt         = '0;
          limit_nxt         = WALK_LIMIT;
          mode_nxt          = W_SCAN;
          chain_req.rd_addr = dir_rd_data;
          state_nxt         = S_WALK;
        end
      end

      // Pick the new sector, or fail when the disk is full.
      S_APP_EVAL: begin
        if (cand >= (TABLE_AW+1)'(FULL_LIMIT)) begin
          res_value_nxt = NONE_MARK;
          res_fail_nxt  = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          next_nxt        = cand[TABLE_AW-1:0];
          dir_req.rd_addr = num_r;
          state_nxt       = S_APP_TGT;
        end
      end

      // Link the new sector into an empty file, or walk to the file's tail.
      S_APP_TGT: begin
        if (dir_rd_data == NONE_MARK) begin
          dir_req.wr_en   = 1'b1;
          dir_req.wr_addr = num_r;
          dir_req.wr_data = next_r;
          state_nxt       = S_APP_CLR;
        end else begin
          cur_nxt           = dir_rd_data;
          links_nxt         = '0;
          limit_nxt         = WALK_LIMIT;
          mode_nxt          = W_TAIL;
          chain_req.rd_addr = dir_rd_data;
          state_nxt         = S_WALK;
        end
      end

      // Terminate the new sector's chain.
      S_APP_CLR: begin
        chain_req.wr_en   = 1'b1;
        chain_req.wr_addr = next_r;
        chain_req.wr_data = NONE_MARK;
        res_value_nxt     = next_r;
        res_fail_nxt      = 1'b0;
        state_nxt         = S_DONE;
      end

      // Hand the result word to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_failed_nxt = res_fail_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    num_r        <= num_nxt;
    loc_r        <= loc_nxt;
    idx_r        <= idx_nxt;
    val_r        <= val_nxt;
    cur_r        <= cur_nxt;
    links_r      <= links_nxt;
    limit_r      <= limit_nxt;
    mode_r       <= mode_nxt;
    i_r          <= i_nxt;
    any_r        <= any_nxt;
    high_r       <= high_nxt;
    next_r       <= next_nxt;
    res_value_r  <= res_value_nxt;
    res_fail_r   <= res_fail_nxt;
    out_value_r  <= out_value_nxt;
    out_failed_r <= out_failed_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/fat_chain_table_engine.sv =====
// Chain table engine: directory and chain tables with file allocation commands.
//
// Usage: commands enter on in_ch (valid/ready); each command word yields exactly
// one result word on out_ch (result_value, failed). Commands run one at a time:
// in_ch.ready is high only while the sequencer is idle, and the next word is
// taken while the previous result still waits in the output register.
// Walks follow one chain link per cycle; the single read port of each table
// sets that pace.
// Reset (rst_n low, synchronous) clears per-entry written flags, so both tables
// read as formatted (all entries 255) once reset ends; no clearing pass.
// If out_ch.ready stays low, the result holds in the output register, one more
// command may be accepted and run, and its result waits until the slot frees.
`timescale 1ns / 1ps
`default_nettype none

`include "fat_chain_table_engine_assert.svh"

module fat_chain_table_engine import fct_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  fct_in_if.sink    in_ch,
  fct_out_if.source out_ch
);

  fct_mem_req_t        dir_req;
  fct_mem_req_t        chain_req;
  logic [TABLE_AW-1:0] dir_rd_data;
  logic [TABLE_AW-1:0] chain_rd_data;

  // Sequence commands.
  fct_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .dir_req       (dir_req),
    .chain_req     (chain_req),
    .dir_rd_data   (dir_rd_data),
    .chain_rd_data (chain_rd_data)
  );

  // First sector per file.
  fct_table u_dir_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (dir_req),
    .rd_data (dir_rd_data)
  );

  // Next sector per sector.
  fct_table u_chain_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (chain_req),
    .rd_data (chain_rd_data)
  );

  // Check sequencing of commands and table updates.
  `FCT_ASSERT_NEXT(a_one_at_a_time, in_ch.valid && in_ch.ready, !in_ch.ready, "accepted a word while busy")
  `FCT_ASSERT_SAME(a_no_write_idle, dir_req.wr_en || chain_req.wr_en, !in_ch.ready, "table write while idle")
  `FCT_ASSERT_SAME(a_single_write, dir_req.wr_en, !chain_req.wr_en, "both tables written in one cycle")

endmodule

`default_nettype wire

// ===== sim/fct_table_checker.sv =====
// Scoreboard for the chain table engine: mirrors both tables and checks every result word.
`timescale 1ns / 1ps

module fct_table_checker import fct_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  fct_in_if    in_ch,
  fct_out_if   out_ch,
  output int   mismatch_count,
  output int   pending,
  output int   failed_results
);

  typedef struct packed {
    fct_cmd_t            cmd;
    logic [TABLE_AW-1:0] file_num;
    logic [TABLE_AW-1:0] location;
    logic [TABLE_AW-1:0] entry_index;
    logic [TABLE_AW-1:0] entry_value;
  } cmd_word_t;

  typedef struct packed {
    fct_cmd_t            cmd;
    logic [TABLE_AW-1:0] result_value;
    logic                failed;
  } result_word_t;

  // Mirror of the directory and chain tables
  logic [TABLE_AW-1:0] dir_mirror   [TABLE_DEPTH];
  logic [TABLE_AW-1:0] chain_mirror [TABLE_DEPTH];

  result_word_t predicted_results [$];
  cmd_word_t    taken_word;
  result_word_t predicted;
  result_word_t oldest;
  int           bad_words;
  int           fail_words;

  // Walk a chain from a used start; stop at the end mark or after the link cap.
  task automatic follow_chain(input logic [TABLE_AW-1:0] start,
                              output logic [TABLE_AW-1:0] last, output int links);
    logic [TABLE_AW-1:0] cur;
    int n;
    cur = start;
    n = 0;
    while (chain_mirror[cur] != NONE_MARK && n < int'(WALK_LIMIT)) begin
      cur = chain_mirror[cur];
      n++;
    end
    last = cur;
    links = n;
  endtask

  // Sector count of a file, saturated at 255.
  task automatic file_length(input logic [TABLE_AW-1:0] file_id, output int len);
    logic [TABLE_AW-1:0] last;
    int links;
    if (dir_mirror[file_id] == NONE_MARK) begin
      len = 0;
    end else begin
      follow_chain(dir_mirror[file_id], last, links);
      len = (links + 1 > 255) ? 255 : links + 1;
    end
  endtask

  // Apply one command word to the mirror and work out its result word.
  task automatic run_table_command(input cmd_word_t w, output result_word_t r);
    int i;
    int links;
    int high;
    int next_sector;
    int len;
    logic [TABLE_AW-1:0] last;
    logic [TABLE_AW-1:0] cur;
    r.cmd = w.cmd;
    r.result_value = '0;
    r.failed = 1'b0;
    case (w.cmd)
      CMD_WR_DIR: begin
        dir_mirror[w.entry_index] = w.entry_value;
      end
      CMD_WR_CHAIN: begin
        chain_mirror[w.entry_index] = w.entry_value;
      end
      CMD_RD_DIR: begin
        r.result_value = dir_mirror[w.entry_index];
      end
      CMD_RD_CHAIN: begin
        r.result_value = chain_mirror[w.entry_index];
      end
      CMD_NEW: begin
        i = 0;
        while (i < int'(NEW_LAST) + 1 && dir_mirror[i] != NONE_MARK) i++;
        r.result_value = TABLE_AW'(i);
        r.failed = (i == int'(NEW_LAST) + 1);
      end
      CMD_SIZE: begin
        file_length(w.file_num, len);
        r.result_value = TABLE_AW'(len);
      end
      CMD_APPEND: begin
        // Highest last sector over the leading run of used directory entries
        high = -1;
        i = 0;
        while (i < TABLE_DEPTH && dir_mirror[i] != NONE_MARK) begin
          follow_chain(dir_mirror[i], last, links);
          if (int'(last) > high) high = int'(last);
          i++;
        end
        next_sector = high + 1;
        if (next_sector >= FULL_LIMIT) begin
          r.result_value = NONE_MARK;
          r.failed = 1'b1;
        end else begin
          if (dir_mirror[w.file_num] == NONE_MARK) begin
            dir_mirror[w.file_num] = TABLE_AW'(next_sector);
          end else begin
            follow_chain(dir_mirror[w.file_num], last, links);
            chain_mirror[last] = TABLE_AW'(next_sector);
          end
          chain_mirror[next_sector] = NONE_MARK;
          r.result_value = TABLE_AW'(next_sector);
        end
      end
      CMD_LOCATE: begin
        file_length(w.file_num, len);
        if (len == 0 || int'(w.location) + 1 > len) begin
          r.result_value = NONE_MARK;
          r.failed = 1'b1;
        end else begin
          cur = dir_mirror[w.file_num];
          for (i = 0; i < int'(w.location); i++) cur = chain_mirror[cur];
          r.result_value = cur;
        end
      end
      default: begin
        r.result_value = '0;
      end
    endcase
  endtask

  // Check result words first, then predict the word taken at this edge
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        dir_mirror[i] = NONE_MARK;
        chain_mirror[i] = NONE_MARK;
      end
      predicted_results.delete();
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (out_ch.failed === 1'b1) fail_words++;
        if (predicted_results.size() == 0) begin
          bad_words++;
          if (bad_words <= 10)
            $display("%0t: result word with none outstanding: value %0d failed %0b",
                     $time, out_ch.result_value, out_ch.failed);
        end else begin
          oldest = predicted_results.pop_front();
          if (out_ch.result_value !== oldest.result_value ||
              out_ch.failed !== oldest.failed) begin
            bad_words++;
            if (bad_words <= 10)
              $display("%0t: %s mismatch: expected value %0d failed %0b, got value %0d failed %0b",
                       $time, oldest.cmd.name(), oldest.result_value, oldest.failed,
                       out_ch.result_value, out_ch.failed);
          end
        end
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        taken_word.cmd = fct_cmd_t'(in_ch.command);
        taken_word.file_num = in_ch.file_num;
        taken_word.location = in_ch.location;
        taken_word.entry_index = in_ch.entry_index;
        taken_word.entry_value = in_ch.entry_value;
        run_table_command(taken_word, predicted);
        predicted_results.push_back(predicted);
      end
    end
    mismatch_count <= bad_words;
    pending <= predicted_results.size();
    failed_results <= fail_words;
  end

endmodule

// ===== sim/fat_chain_table_engine_test.sv =====
// Top of the chain table engine testbench: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module fat_chain_table_engine_test;
  import fct_pkg::*;

  typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC, SINK_SPARSE} sink_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  fct_in_if  in_ch ();
  fct_out_if out_ch ();

  int mismatch_count;
  int results_pending;
  int failed_results;

  // Stimulus bookkeeping
  bit dir_dirty [TABLE_DEPTH];
  int file_len  [32];
  int sectors_used;
  int burst_left;
  int words_sent;
  int appends_sent;

  fat_chain_table_engine uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fct_table_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatch_count),
    .pending        (results_pending),
    .failed_results (failed_results)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int junk();
    return $urandom_range(0, 255);
  endfunction

  // Drive one command word in bursts and hold it until the engine takes it.
  task automatic send_word(input fct_cmd_t c, input int num, input int loc,
                           input int idx, input int val);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 16);
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.command     <= c;
    in_ch.file_num    <= TABLE_AW'(num);
    in_ch.location    <= TABLE_AW'(loc);
    in_ch.entry_index <= TABLE_AW'(idx);
    in_ch.entry_value <= TABLE_AW'(val);
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    words_sent++;
    // Remember directory entries that may no longer read as free
    if (c == CMD_APPEND) begin
      appends_sent++;
      dir_dirty[num & 255] = 1'b1;
    end
    if (c == CMD_WR_DIR && val != int'(NONE_MARK)) dir_dirty[idx & 255] = 1'b1;
  endtask

  // Hold off the sender until every outstanding result word is back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (results_pending != 0);
  endtask

  // One session: clear used files, create them in order, then mix operations.
  task automatic run_episode(input int files, input int words, input bit to_full);
    int k;
    int n;
    int f;
    int pick;
    int sel;
    int loc;
    if ($urandom_range(0, 1) == 0) wait_drained();
    for (k = 0; k < TABLE_DEPTH; k++) begin
      if (dir_dirty[k]) begin
        send_word(CMD_WR_DIR, junk(), junk(), k, int'(NONE_MARK));
        dir_dirty[k] = 1'b0;
      end
    end
    sectors_used = 0;
    for (k = 0; k < 32; k++) file_len[k] = 0;
    for (k = 0; k < files; k++) begin
      send_word(CMD_NEW, junk(), junk(), junk(), junk());
      send_word(CMD_APPEND, k, junk(), junk(), junk());
      sectors_used++;
      file_len[k]++;
    end
    for (n = 0; n < words; n++) begin
      pick = $urandom_range(0, 99);
      if (to_full) pick = (pick < 92) ? 10 : $urandom_range(40, 79);
      f = $urandom_range(0, files - 1);
      if (pick < 8) begin
        // Noise: any command with any field values
        send_word(fct_cmd_t'($urandom_range(0, 7)), junk(), junk(), junk(), junk());
      end else if (pick < 40) begin
        send_word(CMD_APPEND, f, junk(), junk(), junk());
        if (sectors_used < 255) begin
          sectors_used++;
          file_len[f]++;
        end
      end else if (pick < 60) begin
        send_word(CMD_SIZE, f, junk(), junk(), junk());
      end else if (pick < 80) begin
        sel = $urandom_range(0, 9);
        if (sel < 7 && file_len[f] > 0) loc = $urandom_range(0, file_len[f] - 1);
        else if (sel < 9) loc = (file_len[f] > 255) ? 255 : file_len[f];
        else loc = junk();
        send_word(CMD_LOCATE, f, loc, junk(), junk());
      end else if (pick < 88) begin
        send_word(CMD_RD_DIR, junk(), junk(), $urandom_range(0, files), junk());
      end else if (pick < 96) begin
        send_word(CMD_RD_CHAIN, junk(), junk(),
                  $urandom_range(0, (sectors_used > 255) ? 255 : sectors_used), junk());
      end else begin
        send_word(CMD_NEW, junk(), junk(), junk(), junk());
      end
    end
  endtask

  // Fill the whole directory over a cyclic chain, with and without the last entry.
  task automatic fill_directory();
    int i;
    send_word(CMD_WR_CHAIN, junk(), junk(), 3, 5);
    send_word(CMD_WR_CHAIN, junk(), junk(), 5, 3);
    for (i = 0; i < 255; i++) send_word(CMD_WR_DIR, junk(), junk(), i, $urandom_range(0, 15));
    send_word(CMD_NEW, junk(), junk(), junk(), junk());
    send_word(CMD_APPEND, junk(), junk(), junk(), junk());
    send_word(CMD_SIZE, $urandom_range(0, 254), junk(), junk(), junk());
    send_word(CMD_LOCATE, junk(), junk(), junk(), junk());
    send_word(CMD_WR_DIR, junk(), junk(), 255, $urandom_range(0, 15));
    send_word(CMD_APPEND, junk(), junk(), junk(), junk());
    send_word(CMD_NEW, junk(), junk(), junk(), junk());
    send_word(CMD_APPEND, 255, junk(), junk(), junk());
    send_word(CMD_RD_DIR, junk(), junk(), 255, junk());
  endtask

  // Result side: stall on a changing pattern
  initial begin : result_sink
    sink_mode_t mode;
    int mode_left;
    int phase;
    out_ch.ready = 1'b0;
    mode = SINK_OPEN;
    mode_left = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode = sink_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      phase++;
      case (mode)
        SINK_OPEN:     out_ch.ready <= 1'b1;
        SINK_RANDOM:   out_ch.ready <= ($urandom_range(0, 3) != 0);
        SINK_PERIODIC: out_ch.ready <= (phase % 8 >= 3);
        default:       out_ch.ready <= ($urandom_range(0, 11) == 0);
      endcase
    end
  end

  // Command side: directed opening, random sessions, full directory, verdict
  initial begin : stimulus
    int ep;
    int files;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_WR_DIR;
    in_ch.file_num = '0;
    in_ch.location = '0;
    in_ch.entry_index = '0;
    in_ch.entry_value = '0;
    burst_left = 0;
    words_sent = 0;
    appends_sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Formatted tables, first file, short and out-of-range lookups
    send_word(CMD_RD_DIR, junk(), junk(), 0, junk());
    send_word(CMD_RD_CHAIN, junk(), junk(), 255, junk());
    send_word(CMD_NEW, junk(), junk(), junk(), junk());
    send_word(CMD_SIZE, 0, junk(), junk(), junk());
    send_word(CMD_LOCATE, 0, 0, junk(), junk());
    send_word(CMD_APPEND, 0, junk(), junk(), junk());
    send_word(CMD_APPEND, 0, junk(), junk(), junk());
    send_word(CMD_APPEND, 255, junk(), junk(), junk());
    send_word(CMD_SIZE, 0, junk(), junk(), junk());
    send_word(CMD_LOCATE, 0, 1, junk(), junk());
    send_word(CMD_LOCATE, 0, 2, junk(), junk());
    send_word(CMD_LOCATE, 255, 0, junk(), junk());
    send_word(CMD_NEW, junk(), junk(), junk(), junk());
    // Close file 0 on itself: size saturates, walks stop at the link cap
    send_word(CMD_WR_CHAIN, junk(), junk(), 1, 0);
    send_word(CMD_SIZE, 0, junk(), junk(), junk());
    send_word(CMD_LOCATE, 0, 254, junk(), junk());
    send_word(CMD_LOCATE, 0, 255, junk(), junk());
    send_word(CMD_APPEND, 0, junk(), junk(), junk());
    // Disk full just at the table sector, then the last usable sector
    send_word(CMD_WR_DIR, junk(), junk(), 0, 254);
    send_word(CMD_WR_CHAIN, junk(), junk(), 254, 255);
    send_word(CMD_APPEND, 7, junk(), junk(), junk());
    send_word(CMD_WR_DIR, junk(), junk(), 0, 253);
    send_word(CMD_APPEND, 7, junk(), junk(), junk());
    send_word(CMD_RD_DIR, junk(), junk(), 7, junk());
    send_word(CMD_WR_CHAIN, junk(), junk(), 0, 255);

    // Random sessions; the third one runs the disk until it is full
    ep = 0;
    while (words_sent < 900) begin
      if (ep == 2) begin
        run_episode(2, 300, 1'b1);
      end else begin
        files = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        run_episode(files, $urandom_range(20, 60), 1'b0);
      end
      ep++;
    end
    fill_directory();

    // Drain, then leave room for any stray result word
    wait_drained();
    repeat (64) @(posedge clk);
    $display("Covered %0d command words, %0d appends, %0d results flagged as failed.",
             words_sent, appends_sent, failed_results);
    $display("Included disk full, full directory, cyclic chains and stalls on both sides.");
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: several times the slowest expected run
  initial begin : watchdog
    #50_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
